@@ sv/assert_macros.svh @@
// Assertion macros shared by the list engine RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check clocked on clk, held off while rstn is low.
`define ALE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("list engine assertion failed");
// Check clocked on clk, active during reset as well.
`define ALE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("list engine assertion failed");
`else
`define ALE_ASSERT(lbl, clk, rstn, prop)
`define ALE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/ale_pkg.sv @@
// Package for the array list engine: sizes, codes, item and control types.
// Used by ale_cell and array_list_engine_unit; depends on nothing.
package ale_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 6;
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        OP_ADD_HEAD  = 3'd0,
        OP_ADD_TAIL  = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_DEL_HEAD  = 3'd3,
        OP_DEL_TAIL  = 3'd4,
        OP_DEL_KEY   = 3'd5,
        OP_READ      = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    // What every cell does at the commit edge
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INS_HEAD,
        ACT_INS_TAIL,
        ACT_INS_KEY,
        ACT_DEL_HEAD,
        ACT_DEL_KEY
    } t_act;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_op              operation;
        t_word            key;
        t_word            value;
        logic [IDX_W-1:0] index;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [6:0]  count;
        t_word       read_value;
    } t_out_item;

    // Broadcast from the controller to the row of cells
    typedef struct packed {
        logic             cmp;
        logic             en;
        t_act             act;
        t_word            key;
        t_word            value;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] index;
    } t_cell_ctl;

endpackage

@@ sv/ale_cell.sv @@
// One list cell: holds a single element and its key match flag.
// Depends on ale_pkg; instanced in a row by array_list_engine_unit.
module ale_cell import ale_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [POS_W-1:0] i_pos,
    input  t_word            i_left_val,
    input  t_word            i_right_val,
    input  logic             i_lt,
    input  logic             i_lt_left,
    input  t_word            i_rd,
    output logic             o_lt,
    output t_word            o_val,
    output t_word            o_rd
);

    t_word r_val;
    t_word n_val;
    logic  r_match;
    logic  in_use;
    logic  sel;

    assign in_use = CNT_W'(i_pos) < i_ctl.count;
    assign sel    = CMP_W'(i_pos) == CMP_W'(i_ctl.index);

    // lt chain: some cell nearer the head matched; o_lt includes this one
    assign o_lt  = i_lt | r_match;
    assign o_val = r_val;
    assign o_rd  = i_rd | (sel ? r_val : '0);

    always_comb begin
        n_val = r_val;
        case (i_ctl.act)
            ACT_INS_HEAD: n_val = (i_pos == '0) ? i_ctl.value : i_left_val;
            ACT_INS_TAIL: begin
                if (CNT_W'(i_pos) == i_ctl.count) n_val = i_ctl.value;
            end
            ACT_INS_KEY: begin
                if (i_lt_left)  n_val = i_left_val;
                else if (i_lt)  n_val = i_ctl.value;
            end
            ACT_DEL_HEAD: n_val = i_right_val;
            ACT_DEL_KEY: begin
                if (o_lt) n_val = i_right_val;
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) r_val <= n_val;
        if (i_ctl.cmp) r_match <= in_use && (r_val == i_ctl.key);
    end

endmodule

@@ sv/array_list_engine_unit.sv @@
// Top level of the array list engine: controller, output register, cell row.
// Depends on ale_pkg, ale_cell and assert_macros.svh.
//
// Usage
//   Input channel i_in_valid / i_in_item / o_in_stall carries one list
//   operation per item; output channel o_out_valid / o_out_item / i_out_stall
//   returns exactly one result item per operation, in order.
//   An item is taken on an edge with valid high and stall low.
// Timing
//   Accept edge, then a compare cycle in which every cell compares its element
//   with the key, then the commit cycle: the first match is picked along the
//   cell row, every cell shifts or loads at once and the result is written
//   to the output register. The next item is taken at the commit edge, so no
//   new item is taken while one is in its compare or commit cycle.
// Reset
//   Synchronous, active low: the list is emptied (count zero), the output
//   valid is cleared and the input is stalled while reset is held; the
//   block is ready as soon as reset is released.
// Back-pressure
//   While a result waits under i_out_stall the commit is held, and with it
//   the input channel; nothing is lost or repeated.
`include "assert_macros.svh"
module array_list_engine_unit import ale_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    t_state           r_state;
    t_state           n_state;
    t_in_item         r_item;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out;

    logic      out_free;
    logic      in_accept;
    logic      commit;
    t_act      act;
    t_status   status;
    t_word     rd_value;
    t_cell_ctl ctl;
    logic      full;
    logic      empty;
    logic      found;

    logic  lt  [CAPACITY+1];
    t_word rd  [CAPACITY+1];
    t_word val [CAPACITY];

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CMP;
            S_CMP:  n_state = S_EXEC;
            S_EXEC: begin
                if (out_free) n_state = i_in_valid ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b0;
        commit     = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_CMP:  o_in_stall = 1'b1;
            S_EXEC: begin
                o_in_stall = !out_free;
                commit     = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
        // no item is taken while reset is held
        if (!i_rst_n) o_in_stall = 1'b1;
    end

    assign full  = r_count == CNT_W'(CAPACITY);
    assign empty = r_count == '0;
    assign found = lt[CAPACITY];

    // operation decode and result
    always_comb begin
        act      = ACT_NONE;
        status   = ST_OK;
        n_count  = r_count;
        rd_value = '0;
        case (r_item.operation)
            OP_ADD_HEAD, OP_ADD_TAIL: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    act     = (r_item.operation == OP_ADD_HEAD) ? ACT_INS_HEAD : ACT_INS_TAIL;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_INS_AFTER: begin
                if (full) begin
                    status = ST_FULL;
                end else if (!found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    act     = ACT_INS_KEY;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    // tail delete only drops the count
                    act     = (r_item.operation == OP_DEL_HEAD) ? ACT_DEL_HEAD : ACT_NONE;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_DEL_KEY: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    act     = ACT_DEL_KEY;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (CMP_W'(r_item.index) < CMP_W'(r_count)) rd_value = rd[CAPACITY];
                else                                         status   = ST_BAD_INDEX;
            end
            default: act = ACT_NONE;
        endcase
    end

    assign ctl.cmp   = r_state == S_CMP;
    assign ctl.en    = commit;
    assign ctl.act   = act;
    assign ctl.key   = r_item.key;
    assign ctl.value = r_item.value;
    assign ctl.count = r_count;
    assign ctl.index = r_item.index;

    assign lt[0] = 1'b0;
    assign rd[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word left_val;
        t_word right_val;
        logic  lt_left;

        if (g == 0) begin : g_first
            assign left_val = '0;
            assign lt_left  = 1'b0;
        end else begin : g_mid
            assign left_val = val[g-1];
            assign lt_left  = lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = val[g+1];
        end

        ale_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_pos       (POS_W'(g)),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .i_lt        (lt[g]),
            .i_lt_left   (lt_left),
            .i_rd        (rd[g]),
            .o_lt        (lt[g+1]),
            .o_val       (val[g]),
            .o_rd        (rd[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_item <= i_in_item;
        if (commit) begin
            r_out.status     <= status;
            r_out.count      <= 7'(n_count);
            r_out.read_value <= rd_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ALE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `ALE_ASSERT(a_cmp_then_exec, i_clk, i_rst_n, (r_state == S_CMP) |=> (r_state == S_EXEC))
    `ALE_ASSERT(a_count_on_commit, i_clk, i_rst_n, (r_count != $past(r_count)) |-> $past(commit))
    `ALE_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && r_count == '0))

endmodule

@@ dv/array_list_engine_unit_tb.sv @@
// Self-checking bench for array_list_engine_unit: a table of directed items,
// then random fill/drain/mixed runs checked by a list predictor in this file.
// Depends on ale_pkg and the engine RTL only.
`timescale 1ns / 100ps
module array_list_engine_unit_tb;
    import ale_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_ITEMS   = 500;
    localparam int TAIL_CYCLES  = 20;
    localparam t_op   OP_UNUSED = t_op'(3'd7);
    localparam t_word W_MIN     = 32'sh8000_0000;
    localparam t_word W_MAX     = 32'sh7fff_ffff;
    localparam t_word W_NEG1    = -32'sd1;
    localparam t_word W_ABSENT  = 32'sd12345;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    typedef struct {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_plan_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    // List predictor state
    t_word list_mem [CAPACITY];
    int    list_len = 0;

    t_out_item result_q [$];
    t_plan_row plan [$];
    int        fails = 0;
    int        cycle_cnt = 0;
    logic      calm = 1'b0;

    array_list_engine_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one operation to the predicted list and returns its result
    function automatic t_out_item list_apply(input t_in_item it);
        t_out_item r;
        int hit;
        int slot;
        int i;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        slot = -1;
        for (i = list_len - 1; i >= 0; i--)
            if (list_mem[i] == it.key) hit = i;
        case (it.operation)
            OP_ADD_HEAD, OP_ADD_TAIL, OP_INS_AFTER: begin
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else if (it.operation == OP_ADD_HEAD) slot = 0;
                else if (it.operation == OP_ADD_TAIL) slot = list_len;
                else if (hit < 0) r.status = ST_NOT_FOUND;
                else slot = hit + 1;
                if (slot >= 0) begin
                    for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
                    list_mem[slot] = it.value;
                    list_len++;
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_KEY: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (it.operation == OP_DEL_HEAD) slot = 0;
                else if (it.operation == OP_DEL_TAIL) slot = list_len - 1;
                else if (hit < 0) r.status = ST_NOT_FOUND;
                else slot = hit;
                if (slot >= 0) begin
                    for (i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (it.index < list_len) r.read_value = list_mem[it.index];
                else r.status = ST_BAD_INDEX;
            end
            default: ;
        endcase
        r.count = 7'(list_len);
        return r;
    endfunction

    function automatic void plan_add(t_op op, t_word key, t_word value,
                                     logic [IDX_W-1:0] index, logic typed,
                                     t_status status, int count, t_word rv);
        t_plan_row row;
        row.item.operation = op;
        row.item.key       = key;
        row.item.value     = value;
        row.item.index     = index;
        row.typed          = typed;
        row.want.status    = status;
        row.want.count     = 7'(count);
        row.want.read_value = rv;
        plan.push_back(row);
    endfunction

    // Small values repeat so that keys collide; extremes turn up often
    function automatic t_word pick_word();
        case ($urandom_range(3))
            0: return t_word'($urandom_range(7));
            1: return $urandom_range(1) ? W_MIN : W_MAX;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_item(t_mix mode);
        t_in_item it;
        int unsigned roll;
        roll = $urandom_range(99);
        case (mode)
            MIX_FILL: begin
                if (roll < 40) it.operation = OP_ADD_TAIL;
                else if (roll < 65) it.operation = OP_ADD_HEAD;
                else if (roll < 90) it.operation = OP_INS_AFTER;
                else if (roll < 95) it.operation = OP_READ;
                else it.operation = t_op'($urandom_range(7));
            end
            MIX_DRAIN: begin
                if (roll < 30) it.operation = OP_DEL_HEAD;
                else if (roll < 55) it.operation = OP_DEL_TAIL;
                else if (roll < 85) it.operation = OP_DEL_KEY;
                else if (roll < 95) it.operation = OP_READ;
                else it.operation = t_op'($urandom_range(7));
            end
            default: it.operation = t_op'($urandom_range(7));
        endcase
        // Mostly a key that is in the list, so searches hit
        if (list_len > 0 && $urandom_range(99) < 75)
            it.key = list_mem[$urandom_range(list_len - 1)];
        else
            it.key = pick_word();
        it.value = pick_word();
        if (list_len > 0 && $urandom_range(99) < 80)
            it.index = IDX_W'($urandom_range(list_len - 1));
        else
            it.index = IDX_W'($urandom_range(63));
        return it;
    endfunction

    task automatic push_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item model_out;
        while (!calm && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        // Item is taken at the coming edge
        model_out = list_apply(it);
        result_q.push_back(typed ? want : model_out);
        @(posedge clk);
    endtask

    initial begin
        t_mix mode;
        int   n_rand;
        int   seg_no;
        plan_add(OP_READ,      '0,       '0,     0,  1, ST_BAD_INDEX, 0, '0);
        plan_add(OP_DEL_HEAD,  '0,       '0,     0,  1, ST_EMPTY,     0, '0);
        plan_add(OP_DEL_TAIL,  W_MAX,    W_MAX,  63, 1, ST_EMPTY,     0, '0);
        plan_add(OP_DEL_KEY,   '0,       '0,     0,  1, ST_EMPTY,     0, '0);
        plan_add(OP_INS_AFTER, '0,       1,      0,  1, ST_NOT_FOUND, 0, '0);
        plan_add(OP_UNUSED,    W_MAX,    W_MAX,  63, 1, ST_OK,        0, '0);
        plan_add(OP_ADD_HEAD,  '0,       W_MIN,  0,  1, ST_OK,        1, '0);
        plan_add(OP_ADD_TAIL,  W_MIN,    W_MAX,  0,  1, ST_OK,        2, '0);
        plan_add(OP_ADD_HEAD,  '0,       W_NEG1, 0,  1, ST_OK,        3, '0);
        plan_add(OP_INS_AFTER, W_MIN,    '0,     0,  1, ST_OK,        4, '0);
        plan_add(OP_READ,      '0,       '0,     0,  1, ST_OK,        4, W_NEG1);
        plan_add(OP_READ,      '0,       '0,     1,  0, ST_OK,        0, '0);
        plan_add(OP_READ,      '0,       '0,     3,  1, ST_OK,        4, W_MAX);
        plan_add(OP_READ,      '0,       '0,     4,  1, ST_BAD_INDEX, 4, '0);
        plan_add(OP_READ,      W_NEG1,   W_NEG1, 63, 1, ST_BAD_INDEX, 4, '0);
        plan_add(OP_INS_AFTER, W_ABSENT, 9,      0,  1, ST_NOT_FOUND, 4, '0);
        plan_add(OP_DEL_KEY,   W_ABSENT, '0,     0,  1, ST_NOT_FOUND, 4, '0);
        // Duplicate value: key operations must take the first match
        plan_add(OP_ADD_TAIL,  '0,       W_NEG1, 0,  0, ST_OK,        0, '0);
        plan_add(OP_DEL_KEY,   W_NEG1,   '0,     0,  0, ST_OK,        0, '0);
        plan_add(OP_INS_AFTER, W_NEG1,   7,      0,  0, ST_OK,        0, '0);
        plan_add(OP_READ,      '0,       '0,     4,  0, ST_OK,        0, '0);
        plan_add(OP_DEL_HEAD,  '0,       '0,     0,  0, ST_OK,        0, '0);
        plan_add(OP_DEL_TAIL,  '0,       '0,     0,  0, ST_OK,        0, '0);
        plan_add(OP_UNUSED,    '0,       '0,     0,  0, ST_OK,        0, '0);
        plan_add(OP_READ,      '0,       '0,     0,  0, ST_OK,        0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
            push_item(plan[r].item, plan[r].typed, plan[r].want);

        n_rand = 0;
        seg_no = 0;
        while (n_rand < RAND_ITEMS) begin
            // Open with a fill so the full store is reached early
            mode = (seg_no == 0) ? MIX_FILL : t_mix'($urandom_range(2));
            repeat ((mode == MIX_BALANCED) ? 40 : 80) begin
                calm = (n_rand >= 200 && n_rand < 320);
                push_item(make_item(mode), 1'b0, '0);
                n_rand++;
            end
            seg_no++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait (result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 10);
    end

    // Stall and valid settle at the rising edge, so the negedge view is the
    // one the next edge acts on
    always @(negedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d count %0d value %0h",
                         $time, out_item.status, out_item.count, out_item.read_value);
                fails++;
            end else begin
                want = result_q.pop_front();
                if (out_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_item.status);
                    fails++;
                end
                if (out_item.count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, out_item.count);
                    fails++;
                end
                if (out_item.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %0h actual %0h",
                             $time, want.read_value, out_item.read_value);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
